// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/gdid_pkg.sv -----
`default_nettype none

package gdid_pkg;

  // Opcodes that the decoder tells apart
  localparam logic [5:0] OP_ADDQ     = 6'd2;
  localparam logic [5:0] OP_ADDQT    = 6'd3;
  localparam logic [5:0] OP_SUBQ     = 6'd6;
  localparam logic [5:0] OP_SUBQT    = 6'd7;
  localparam logic [5:0] OP_BTST     = 6'd13;
  localparam logic [5:0] OP_BSET     = 6'd14;
  localparam logic [5:0] OP_BCLR     = 6'd15;
  localparam logic [5:0] OP_SHLQ     = 6'd24;
  localparam logic [5:0] OP_SHRQ     = 6'd25;
  localparam logic [5:0] OP_SHARQ    = 6'd27;
  localparam logic [5:0] OP_RORQ     = 6'd29;
  localparam logic [5:0] OP_CMPQ     = 6'd31;
  localparam logic [5:0] OP_MOVEQ    = 6'd35;
  localparam logic [5:0] OP_MOVEI    = 6'd38;
  localparam logic [5:0] OP_LOAD_IX0 = 6'd43;
  localparam logic [5:0] OP_LOAD_IX1 = 6'd44;
  localparam logic [5:0] OP_STOR_IX0 = 6'd49;
  localparam logic [5:0] OP_STOR_IX1 = 6'd50;
  localparam logic [5:0] OP_JUMP     = 6'd52;
  localparam logic [5:0] OP_JR       = 6'd53;
  localparam logic [5:0] OP_PACK     = 6'd63;

  localparam logic [5:0]  QUICK_ZERO_VAL = 6'd32;
  localparam logic [31:0] COND_MASK      = 32'h8770_0777;
  localparam logic [31:0] JR_PC_OFFSET   = 32'd2;
  localparam logic [4:0]  PACK_SUB_MAX   = 5'd1;
  localparam logic [2:0]  LEN_SHORT      = 3'd2;
  localparam logic [2:0]  LEN_MOVEI      = 3'd6;

  typedef enum logic [3:0] {
    CLS_NONE  = 4'd0,
    CLS_QUICK = 4'd1,
    CLS_SHL   = 4'd2,
    CLS_RAW   = 4'd3,
    CLS_INDEX = 4'd4,
    CLS_MOVEI = 4'd5,
    CLS_JCOND = 4'd6,
    CLS_JREL  = 4'd7,
    CLS_PACK  = 4'd8
  } gdid_class_e;

  // One complete instruction handed from the front end to the back end
  typedef struct packed {
    logic [15:0] word;
    logic [31:0] addr;
    logic [31:0] movei_val;
    gdid_class_e cls;
  } gdid_instr_t;

  typedef struct packed {
    logic [31:0] instr_addr;
    logic [5:0]  opcode;
    logic [4:0]  field_a;
    logic [4:0]  field_b;
    logic [31:0] imm_value;
    logic        has_imm;
    logic [31:0] target_addr;
    logic        cond_known;
    logic        invalid;
    logic [2:0]  length_bytes;
  } gdid_result_t;

  function automatic gdid_class_e gdid_classify(input logic [5:0] op);
    gdid_class_e cls;
    case (op) inside
      OP_ADDQ, OP_ADDQT, OP_SUBQ, OP_SUBQT, OP_SHRQ, OP_SHARQ, OP_RORQ: cls = CLS_QUICK;
      OP_SHLQ:                                                        cls = CLS_SHL;
      OP_BTST, OP_BSET, OP_BCLR, OP_CMPQ, OP_MOVEQ:                   cls = CLS_RAW;
      OP_LOAD_IX0, OP_LOAD_IX1, OP_STOR_IX0, OP_STOR_IX1:             cls = CLS_INDEX;
      OP_MOVEI:                                                       cls = CLS_MOVEI;
      OP_JUMP:                                                        cls = CLS_JCOND;
      OP_JR:                                                          cls = CLS_JREL;
      OP_PACK:                                                        cls = CLS_PACK;
      default:                                                        cls = CLS_NONE;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- sv/gdid_ifs.sv -----
`default_nettype none

interface gdid_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_word;
  logic [31:0] word_addr;

  modport source (output valid, code_word, word_addr, input ready);
  modport sink (input valid, code_word, word_addr, output ready);
endinterface

interface gdid_dec_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_addr;
  logic [5:0]  opcode;
  logic [4:0]  field_a;
  logic [4:0]  field_b;
  logic [31:0] imm_value;
  logic        has_imm;
  logic [31:0] target_addr;
  logic        cond_known;
  logic        invalid;
  logic [2:0]  length_bytes;

  modport source (
    output valid, instr_addr, opcode, field_a, field_b, imm_value, has_imm,
           target_addr, cond_known, invalid, length_bytes,
    input  ready
  );
  modport sink (
    input  valid, instr_addr, opcode, field_a, field_b, imm_value, has_imm,
           target_addr, cond_known, invalid, length_bytes,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/gdid_front.sv -----
`default_nettype none

module gdid_front
  import gdid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  gdid_word_if.sink        word_i,
  output      logic        push_valid_o,
  input  wire logic        push_ready_i,
  output      gdid_instr_t push_data_o
);

  typedef enum logic [2:0] {
    ST_FIRST = 3'b001,
    ST_LOW   = 3'b010,
    ST_HIGH  = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;
  logic [15:0]  held_word_q, held_word_d;
  logic [31:0]  held_addr_q, held_addr_d;
  logic [15:0]  held_low_q, held_low_d;
  logic         accept;
  logic [5:0]   word_op;
  logic [15:0]  out_word;

  assign word_i.ready = push_ready_i;
  assign accept       = word_i.valid & push_ready_i;
  assign word_op      = word_i.code_word[15:10];

  always_comb begin
    state_d      = state_q;
    held_word_d  = held_word_q;
    held_addr_d  = held_addr_q;
    held_low_d   = held_low_q;
    push_valid_o = 1'b0;
    out_word     = word_i.code_word;
    push_data_o.addr      = word_i.word_addr;
    push_data_o.movei_val = '0;
    case (state_q)
      ST_LOW: begin
        if (accept) begin
          held_low_d = word_i.code_word;
          state_d    = ST_HIGH;
        end
      end
      ST_HIGH: begin
        // second extension word completes the move-immediate
        push_valid_o          = word_i.valid;
        out_word              = held_word_q;
        push_data_o.addr      = held_addr_q;
        push_data_o.movei_val = {word_i.code_word, held_low_q};
        if (accept) begin
          state_d = ST_FIRST;
        end
      end
      default: begin
        if (word_op == OP_MOVEI) begin
          if (accept) begin
            held_word_d = word_i.code_word;
            held_addr_d = word_i.word_addr;
            state_d     = ST_LOW;
          end
        end else begin
          push_valid_o = word_i.valid;
        end
      end
    endcase
    push_data_o.word = out_word;
    push_data_o.cls  = gdid_classify(out_word[15:10]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FIRST;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_word_q <= held_word_d;
    held_addr_q <= held_addr_d;
    held_low_q  <= held_low_d;
  end

endmodule

`default_nettype wire

// ----- sv/gdid_fifo.sv -----
`default_nettype none

module gdid_fifo
  import gdid_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output      logic        push_ready_o,
  input  wire gdid_instr_t push_data_i,
  output      logic        pop_valid_o,
  input  wire logic        pop_ready_i,
  output      gdid_instr_t pop_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gdid_instr_t   mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gdid_back.sv -----
`default_nettype none

module gdid_back
  import gdid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        instr_valid_i,
  output      logic        instr_ready_o,
  input  wire gdid_instr_t instr_i,
  gdid_dec_if.source       dec_o
);

  logic         valid_q;
  gdid_result_t res_q, res_d;
  logic         take;
  logic [4:0]   fa;
  logic [4:0]   fb;
  logic [5:0]   fa32;

  assign instr_ready_o = !valid_q || dec_o.ready;
  assign take          = instr_valid_i & instr_ready_o;

  assign fa   = instr_i.word[9:5];
  assign fb   = instr_i.word[4:0];
  // quick forms encode 32 as 0
  assign fa32 = (fa == '0) ? QUICK_ZERO_VAL : {1'b0, fa};

  always_comb begin
    res_d.instr_addr   = instr_i.addr;
    res_d.opcode       = instr_i.word[15:10];
    res_d.field_a      = fa;
    res_d.field_b      = fb;
    res_d.imm_value    = '0;
    res_d.has_imm      = 1'b0;
    res_d.target_addr  = '0;
    res_d.cond_known   = 1'b0;
    res_d.invalid      = 1'b0;
    res_d.length_bytes = LEN_SHORT;
    case (instr_i.cls)
      CLS_QUICK: begin
        res_d.imm_value = {26'd0, fa32};
        res_d.has_imm   = 1'b1;
      end
      CLS_SHL: begin
        res_d.imm_value = {26'd0, QUICK_ZERO_VAL - fa32};
        res_d.has_imm   = 1'b1;
      end
      CLS_RAW: begin
        res_d.imm_value = {27'd0, fa};
        res_d.has_imm   = 1'b1;
      end
      CLS_INDEX: begin
        res_d.imm_value = {24'd0, fa32, 2'b00};
        res_d.has_imm   = 1'b1;
      end
      CLS_MOVEI: begin
        res_d.imm_value    = instr_i.movei_val;
        res_d.has_imm      = 1'b1;
        res_d.length_bytes = LEN_MOVEI;
      end
      CLS_JCOND: begin
        res_d.cond_known = COND_MASK[fb];
      end
      CLS_JREL: begin
        res_d.target_addr = instr_i.addr + JR_PC_OFFSET + {{26{fa[4]}}, fa, 1'b0};
        res_d.cond_known  = COND_MASK[fb];
      end
      CLS_PACK: begin
        res_d.invalid = (fa > PACK_SUB_MAX);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (instr_ready_o) begin
      valid_q <= instr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign dec_o.valid        = valid_q;
  assign dec_o.instr_addr   = res_q.instr_addr;
  assign dec_o.opcode       = res_q.opcode;
  assign dec_o.field_a      = res_q.field_a;
  assign dec_o.field_b      = res_q.field_b;
  assign dec_o.imm_value    = res_q.imm_value;
  assign dec_o.has_imm      = res_q.has_imm;
  assign dec_o.target_addr  = res_q.target_addr;
  assign dec_o.cond_known   = res_q.cond_known;
  assign dec_o.invalid      = res_q.invalid;
  assign dec_o.length_bytes = res_q.length_bytes;

endmodule

`default_nettype wire

// ----- sv/gpu_dsp_instruction_decoder.sv -----
// Instruction decoder for a 16-bit code word stream.
// word_i: one code word and its byte address per transaction. A single-word
//   instruction completes on its word; a move-immediate takes its first word
//   plus two extension words (low half first), whose addresses are ignored.
// dec_o: one decoded instruction per completed instruction: raw fields,
//   decoded immediate, relative jump target, condition and subcode flags.
// Throughput: one code word per cycle while the queue has room. The instruction
//   queue is written at the edge that accepts the instruction's last word, the
//   decode register in the back end when it takes the entry from the queue;
//   dec_o.valid is driven from that register.
// Stall: the output register holds while dec_o.ready is low; the front end
//   keeps filling the queue (QUEUE_DEPTH entries) and word_i.ready drops
//   only once the queue is full.
// Reset: queue and output empty, the front end expects a first word.
// QUEUE_DEPTH: 2 or more.
`default_nettype none

module gpu_dsp_instruction_decoder
  import gdid_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  gdid_word_if.sink   word_i,
  gdid_dec_if.source  dec_o
);

  logic        push_valid, push_ready;
  gdid_instr_t push_data;
  logic        pop_valid, pop_ready;
  gdid_instr_t pop_data;

  gdid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  gdid_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gdid_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .instr_valid_i (pop_valid),
    .instr_ready_o (pop_ready),
    .instr_i       (pop_data),
    .dec_o         (dec_o)
  );

endmodule

`default_nettype wire

// ----- sv/gdid_chk.sv -----
`default_nettype none
`include "assert_macros.svh"

module gdid_chk
  import gdid_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [31:0] instr_addr_i,
  input wire logic [5:0]  opcode_i,
  input wire logic [31:0] imm_value_i,
  input wire logic        has_imm_i,
  input wire logic [31:0] target_addr_i,
  input wire logic        invalid_i,
  input wire logic [2:0]  length_bytes_i
);

  logic        len_ok;
  logic        imm_stray;
  logic        tgt_stray;
  logic        inv_ok;
  logic        stall;
  logic [63:0] out_key;

  assign len_ok    = ((length_bytes_i == LEN_MOVEI) == (opcode_i == OP_MOVEI)) &&
                     ((length_bytes_i == LEN_MOVEI) || (length_bytes_i == LEN_SHORT));
  assign imm_stray = !has_imm_i && (imm_value_i != '0);
  assign tgt_stray = (opcode_i != OP_JR) && (target_addr_i != '0);
  assign inv_ok    = !invalid_i || (opcode_i == OP_PACK);
  assign stall     = valid_i && !ready_i;
  assign out_key   = {instr_addr_i, imm_value_i};

  `ASSERT_IMPL(a_len_movei, clk_i, rst_ni, valid_i, len_ok, "length does not match opcode")
  `ASSERT_IMPL(a_imm_zero, clk_i, rst_ni, valid_i, !imm_stray, "immediate set without has_imm")
  `ASSERT_IMPL(a_tgt_jr, clk_i, rst_ni, valid_i, !tgt_stray, "target set for non-relative jump")
  `ASSERT_IMPL(a_inv_pack, clk_i, rst_ni, valid_i, inv_ok, "invalid flag outside pack opcode")
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stall, valid_i && $stable(out_key), "stall not held")

endmodule

bind gpu_dsp_instruction_decoder gdid_chk u_gdid_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (dec_o.valid),
  .ready_i        (dec_o.ready),
  .instr_addr_i   (dec_o.instr_addr),
  .opcode_i       (dec_o.opcode),
  .imm_value_i    (dec_o.imm_value),
  .has_imm_i      (dec_o.has_imm),
  .target_addr_i  (dec_o.target_addr),
  .invalid_i      (dec_o.invalid),
  .length_bytes_i (dec_o.length_bytes)
);

`default_nettype wire
